### rtl/core/lru_page_replacement_top_assert.svh
// Assertion macros shared by the page replacement tracker RTL.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LRU_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define LRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/lru_pkg.sv
// Package for the page replacement tracker: sizes, result type, capacity helper.
// Used by lru_core and lru_page_replacement_top; depends on nothing.
package lru_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int PAGE_W      = 8;
  localparam int CAP_W       = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(MAX_ENTRIES);

  typedef logic [PAGE_W-1:0] page_t;
  typedef logic [CNT_W-1:0]  count_t;
  typedef logic [CAP_W-1:0]  cap_t;

  typedef struct packed {
    logic   hit;
    logic   evicted;
    page_t  evicted_page;
    count_t resident_count;
  } lru_result_t;

  // A zero capacity acts as one; anything above the built depth saturates.
  function automatic count_t eff_capacity(input cap_t cap);
    count_t res;
    if (cap == '0) begin
      res = count_t'(1);
    end else if (32'(cap) > MAX_ENTRIES) begin
      res = count_t'(MAX_ENTRIES);
    end else begin
      res = count_t'(cap);
    end
    return res;
  endfunction

endpackage

### rtl/core/lru_core.sv
// Recency list of resident pages with parallel compare and a reorder registered on each step.
// Depends on lru_pkg and the assertion macro header.
`include "lru_page_replacement_top_assert.svh"

module lru_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  lru_pkg::page_t      page,
  input  lru_pkg::count_t     cap_eff,
  output lru_pkg::lru_result_t result
);
  import lru_pkg::*;

  page_t  entries_r   [MAX_ENTRIES];
  page_t  entries_nxt [MAX_ENTRIES];
  count_t occ_r;
  count_t occ_nxt;

  logic [MAX_ENTRIES-1:0] match;
  logic                   hit;
  logic                   room;
  logic [IDX_W-1:0]       pos;
  count_t                 last;
  count_t                 occ_m1;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match[i] = (count_t'(i) < occ_r) && (entries_r[i] == page);
    end
    hit = |match;
    pos = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        pos = IDX_W'(i);
      end
    end
    room   = occ_r < cap_eff;
    occ_m1 = occ_r - count_t'(1);

    priority if (hit) begin
      last = count_t'(pos);
    end else if (room) begin
      last = occ_r;
    end else begin
      last = occ_m1;
    end

    entries_nxt[0] = page;
    for (int i = 1; i < MAX_ENTRIES; i++) begin
      entries_nxt[i] = (count_t'(i) <= last) ? entries_r[i-1] : entries_r[i];
    end

    occ_nxt = (!hit && room) ? occ_r + count_t'(1) : occ_r;

    result.hit            = hit;
    result.evicted        = !hit && !room;
    result.evicted_page   = (!hit && !room) ? entries_r[occ_m1[IDX_W-1:0]] : '0;
    result.resident_count = occ_nxt;
  end

  always_ff @(posedge clk) begin
    if (step) begin
      entries_r <= entries_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (step) begin
      occ_r <= occ_nxt;
    end
  end

  `LRU_ASSERT_ALWAYS(a_occ_bound, 32'(occ_r) <= MAX_ENTRIES, "occupancy above depth")
  `LRU_ASSERT_ALWAYS(a_hit_no_evict, !(result.hit && result.evicted), "hit and eviction together")
  `LRU_ASSERT_NEXT(a_front_page, step, entries_r[0] == $past(page), "page not at front")
  `LRU_ASSERT_NEXT(a_occ_grow, step && !hit && room, occ_r == $past(occ_r) + count_t'(1),
    "occupancy did not grow on miss with room")

endmodule

### rtl/core/lru_page_replacement_top.sv
// A reference passes the input register, then the result register; out_stall can hold it back.
// Throughput: one reference per cycle while out_stall is low; all entries are compared at once.
// Reset (synchronous, rst_n low) empties the list and sets capacity to the full depth.
// Top level of the page replacement tracker: input register, core, result register.
// Depends on lru_pkg, lru_core and the assertion macro header.
`include "lru_page_replacement_top_assert.svh"

module lru_page_replacement_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lru_pkg::page_t        in_page_id,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_hit,
  output logic                  out_evicted,
  output lru_pkg::page_t        out_evicted_page,
  output lru_pkg::count_t       out_resident_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  lru_pkg::cap_t         cfg_wdata
);
  import lru_pkg::*;

  logic        stage_valid_r;
  logic        stage_valid_nxt;
  page_t       stage_page_r;
  logic        out_valid_r;
  logic        out_valid_nxt;
  lru_result_t res_r;
  lru_result_t res;
  cap_t        cap_r;
  logic        fire;
  logic        accept;

  assign fire      = stage_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = stage_valid_r && !fire;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (fire) begin
      stage_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  lru_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (fire),
    .page    (stage_page_r),
    .cap_eff (eff_capacity(cap_r)),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
      cap_r         <= CAP_RESET;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_page_r <= in_page_id;
    end
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = res_r.hit;
  assign out_evicted        = res_r.evicted;
  assign out_evicted_page   = res_r.evicted_page;
  assign out_resident_count = res_r.resident_count;

  `LRU_ASSERT_ALWAYS(a_fire_has_room, !fire || !out_valid_r || !out_stall, "result overwritten")
  `LRU_ASSERT_NEXT(a_fire_gives_out, fire, out_valid_r, "result lost after processing")
  `LRU_ASSERT_NEXT(a_held_stage, stage_valid_r && !fire, stage_valid_r && $stable(stage_page_r),
    "staged item dropped")

endmodule
